// ===== rtl/core/fadf_pkg.sv =====
// Package for the frame admission and dedup filter: shared types, verdict codes,
// register reset values and controller states. No dependencies.
`default_nettype none

package fadf_pkg;

    localparam int RING_DEPTH_DEF = 32;

    localparam logic [31:0] DEDUP_WINDOW_RST = 32'd50000;
    localparam logic [31:0] SEEN_WINDOW_RST  = 32'd3000000;

    localparam logic [1:0] VERDICT_FWD = 2'd0;
    localparam logic [1:0] VERDICT_CRC = 2'd1;
    localparam logic [1:0] VERDICT_DUP = 2'd2;

    // APB register index, taken from paddr[2]
    localparam logic REG_DEDUP_WINDOW = 1'b0;
    localparam logic REG_SEEN_WINDOW  = 1'b1;

    typedef struct packed {
        logic        vehicle_side;
        logic        chk_known;
        logic        chk_pass;
        logic [31:0] frame_hash;
        logic [47:0] now_us;
        logic        autopilot_heartbeat;
        logic [7:0]  src_sys_id;
        logic        hb_arm_flag;
        logic        prio_mark;
    } t_frame;

    typedef struct packed {
        logic [1:0] verdict;
        logic       toward_vehicle;
        logic       priority_out;
        logic       armed;
        logic       vehicle_recent;
    } t_result;

    typedef struct packed {
        logic load;
        logic scan_read;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_scan;
        logic last_addr;
        logic out_busy;
    } t_dp_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/frame_admission_dedup_filter.sv =====
// Frame admission and dedup filter, top level: stream ports, APB registers.
// Network frames with a usable checksum are loaded in ST_IDLE, scanned in ST_SCAN
// (one ring entry read per cycle through the single memory read port), finish the
// compare in ST_DRAIN and commit in ST_COMMIT once the output register is free.
// Vehicle and bad-checksum frames skip to ST_COMMIT; new input only in ST_IDLE.
// Reset: synchronous; windows return to defaults, ring valid bits clear at once.
`default_nettype none

module frame_admission_dedup_filter #(
    parameter int RING_DEPTH = fadf_pkg::RING_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // chk_known, chk_pass, frame_hash[31:0], now_us[47:0], src_sys_id[7:0],
    // hb_arm_flag, prio_mark, zero fill
    input  wire  [95:0] s_axis_tdata,
    // vehicle_side, autopilot_heartbeat
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // toward_vehicle, priority_out, armed, vehicle_recent, zero fill
    output logic [7:0]  m_axis_tdata,
    // verdict[1:0]
    output logic [1:0]  m_axis_tuser,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_dedup_window;
    logic [31:0] r_seen_window;
    logic        cfg_wr;

    fadf_pkg::t_frame     frame;
    fadf_pkg::t_result    result;
    fadf_pkg::t_dp_cmd    cmd;
    fadf_pkg::t_dp_status status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == fadf_pkg::REG_SEEN_WINDOW) ? r_seen_window
                                                           : r_dedup_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dedup_window <= fadf_pkg::DEDUP_WINDOW_RST;
            r_seen_window  <= fadf_pkg::SEEN_WINDOW_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                fadf_pkg::REG_DEDUP_WINDOW: r_dedup_window <= pwdata;
                fadf_pkg::REG_SEEN_WINDOW:  r_seen_window  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        frame.vehicle_side        = s_axis_tuser[0];
        frame.autopilot_heartbeat = s_axis_tuser[1];
        frame.chk_known           = s_axis_tdata[0];
        frame.chk_pass            = s_axis_tdata[1];
        frame.frame_hash          = s_axis_tdata[33:2];
        frame.now_us              = s_axis_tdata[81:34];
        frame.src_sys_id          = s_axis_tdata[89:82];
        frame.hb_arm_flag         = s_axis_tdata[90];
        frame.prio_mark           = s_axis_tdata[91];
    end

    fadf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fadf_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_frame        (frame),
        .i_dedup_window (r_dedup_window),
        .i_seen_window  (r_seen_window),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_result       (result)
    );

    assign m_axis_tuser = result.verdict;
    assign m_axis_tdata = {4'd0, result.vehicle_recent, result.armed,
                           result.priority_out, result.toward_vehicle};

endmodule

`default_nettype wire

// ===== rtl/core/fadf_ctrl.sv =====
// Controller state machine of the frame admission and dedup filter.
// Sequences input capture, ring scan and commit. Depends on fadf_pkg.
`default_nettype none

module fadf_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  fadf_pkg::t_dp_status i_status,
    output fadf_pkg::t_dp_cmd    o_cmd
);

    fadf_pkg::t_state r_state;
    fadf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fadf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            fadf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.need_scan ? fadf_pkg::ST_SCAN
                                                    : fadf_pkg::ST_COMMIT;
                end
            end
            fadf_pkg::ST_SCAN: begin
                o_cmd.scan_read = 1'b1;
                if (i_status.last_addr) begin
                    n_state = fadf_pkg::ST_DRAIN;
                end
            end
            fadf_pkg::ST_DRAIN: begin
                // last ring entry is compared in this cycle
                n_state = fadf_pkg::ST_COMMIT;
            end
            fadf_pkg::ST_COMMIT: begin
                // hold until the output register can take the result
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = fadf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fadf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/fadf_datapath.sv =====
// Datapath of the frame admission and dedup filter: frame register, hash ring
// memory with valid bits, duplicate compare, vehicle state and output register.
// Depends on fadf_pkg.
`default_nettype none

module fadf_datapath #(
    parameter int RING_DEPTH = fadf_pkg::RING_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  fadf_pkg::t_dp_cmd     i_cmd,
    output fadf_pkg::t_dp_status  o_status,
    input  fadf_pkg::t_frame      i_frame,
    input  wire [31:0]            i_dedup_window,
    input  wire [31:0]            i_seen_window,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output fadf_pkg::t_result     o_result
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0] LastAddr = AW'(RING_DEPTH - 1);

    logic [31:0] mem_hash [RING_DEPTH];
    logic [47:0] mem_time [RING_DEPTH];

    fadf_pkg::t_frame  r_frame;
    fadf_pkg::t_result r_result;
    fadf_pkg::t_result n_result;

    logic [RING_DEPTH-1:0] r_valid;
    logic [AW-1:0]         r_addr;
    logic [AW-1:0]         r_cursor;
    logic                  r_rd_pend;
    logic                  r_rd_ok;
    logic [31:0]           r_rd_hash;
    logic [47:0]           r_rd_time;
    logic                  r_dup;
    logic                  n_dup;
    logic                  r_pinned;
    logic [7:0]            r_pinned_sys;
    logic                  r_armed;
    logic                  n_armed;
    logic [47:0]           r_lvt;
    logic                  r_out_valid;

    logic        crc_bad;
    logic        veh_upd;
    logic        ring_wr;
    logic        hit;
    logic [31:0] eff_hash;
    logic [47:0] eff_time;
    logic [47:0] age;
    logic [47:0] since_vehicle;
    logic        sys_match;

    // frames from the network side with a usable checksum need the ring scan
    assign o_status.need_scan = !i_frame.vehicle_side &&
                                !(i_frame.chk_known && !i_frame.chk_pass);
    assign o_status.last_addr = (r_addr == LastAddr);
    assign o_status.out_busy  = r_out_valid && !i_out_ready;

    // an entry never written reads as hash zero at time zero
    assign eff_hash = r_rd_ok ? r_rd_hash : 32'd0;
    assign eff_time = r_rd_ok ? r_rd_time : 48'd0;
    assign age      = r_frame.now_us - eff_time;
    assign hit      = r_rd_pend && (eff_hash == r_frame.frame_hash) &&
                      (age < {16'd0, i_dedup_window});
    assign n_dup    = i_cmd.load ? 1'b0 : (r_dup | hit);

    assign crc_bad   = r_frame.chk_known && !r_frame.chk_pass;
    assign veh_upd   = !crc_bad && r_frame.vehicle_side;
    assign ring_wr   = !crc_bad && !r_frame.vehicle_side && !r_dup;
    assign sys_match = !r_pinned || (r_frame.src_sys_id == r_pinned_sys);
    assign n_armed   = (veh_upd && r_frame.autopilot_heartbeat && sys_match)
                       ? r_frame.hb_arm_flag : r_armed;
    assign since_vehicle = r_frame.now_us - r_lvt;

    always_comb begin
        priority if (crc_bad) begin
            n_result.verdict = fadf_pkg::VERDICT_CRC;
        end else if (!r_frame.vehicle_side && r_dup) begin
            n_result.verdict = fadf_pkg::VERDICT_DUP;
        end else begin
            n_result.verdict = fadf_pkg::VERDICT_FWD;
        end
        n_result.toward_vehicle = (n_result.verdict == fadf_pkg::VERDICT_FWD) &&
                                  !r_frame.vehicle_side;
        n_result.priority_out   = (n_result.verdict == fadf_pkg::VERDICT_FWD) &&
                                  r_frame.prio_mark;
        n_result.armed          = n_armed;
        // a vehicle frame sets the last-seen time to now, so the age is zero
        n_result.vehicle_recent = veh_upd ? (i_seen_window != 32'd0)
                                          : (since_vehicle < {16'd0, i_seen_window});
    end

    // ring memory: written at commit, read during the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && ring_wr) begin
            mem_hash[r_cursor] <= r_frame.frame_hash;
            mem_time[r_cursor] <= r_frame.now_us;
        end
        if (i_cmd.scan_read) begin
            r_rd_hash <= mem_hash[r_addr];
            r_rd_time <= mem_time[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frame <= i_frame;
        end
        if (i_cmd.commit) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_addr       <= '0;
            r_cursor     <= '0;
            r_rd_pend    <= 1'b0;
            r_rd_ok      <= 1'b0;
            r_dup        <= 1'b0;
            r_pinned     <= 1'b0;
            r_pinned_sys <= 8'd0;
            r_armed      <= 1'b0;
            r_lvt        <= 48'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.scan_read;
            r_dup     <= n_dup;
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.scan_read) begin
                r_addr  <= r_addr + AW'(1);
                r_rd_ok <= r_valid[r_addr];
            end
            if (i_cmd.commit) begin
                r_armed <= n_armed;
                if (veh_upd) begin
                    r_lvt <= r_frame.now_us;
                    if (r_frame.autopilot_heartbeat && !r_pinned) begin
                        r_pinned     <= 1'b1;
                        r_pinned_sys <= r_frame.src_sys_id;
                    end
                end
                if (ring_wr) begin
                    r_valid[r_cursor] <= 1'b1;
                    r_cursor <= (r_cursor == LastAddr) ? '0 : r_cursor + AW'(1);
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

// ===== verif/fadf_checker.sv =====
// Checker for frame_admission_dedup_filter: watches the APB port and both stream channels,
// predicts each result from its own copy of the filter state and compares in order.
// Depends on fadf_pkg for the frame, result and verdict definitions.
module fadf_checker #(
    parameter int RING_DEPTH = fadf_pkg::RING_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_tvalid,
    input  wire         i_in_tready,
    input  wire  [95:0] i_in_tdata,
    input  wire  [1:0]  i_in_tuser,
    input  wire         i_out_tvalid,
    input  wire         i_out_tready,
    input  wire  [7:0]  i_out_tdata,
    input  wire  [1:0]  i_out_tuser,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    input  wire         i_pready,
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] dedup_window = fadf_pkg::DEDUP_WINDOW_RST;
    logic [31:0] seen_window  = fadf_pkg::SEEN_WINDOW_RST;
    logic [31:0] hash_ring [RING_DEPTH];
    logic [47:0] stamp_ring [RING_DEPTH];
    int unsigned ring_pos = 0;
    logic        id_pinned = 1'b0;
    logic [7:0]  pinned_id = 8'd0;
    logic        armed_now = 1'b0;
    logic [47:0] last_vehicle_us = 48'd0;

    fadf_pkg::t_result expected_results [$];
    int      fail_count = 0;
    int      outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    function automatic fadf_pkg::t_frame unpack_frame(input logic [95:0] d,
                                                      input logic [1:0] u);
        fadf_pkg::t_frame f;
        f.vehicle_side        = u[0];
        f.autopilot_heartbeat = u[1];
        f.chk_known           = d[0];
        f.chk_pass            = d[1];
        f.frame_hash          = d[33:2];
        f.now_us              = d[81:34];
        f.src_sys_id          = d[89:82];
        f.hb_arm_flag         = d[90];
        f.prio_mark           = d[91];
        return f;
    endfunction

    // Apply one frame to the filter state and return the result it must produce.
    function fadf_pkg::t_result admit_frame(input fadf_pkg::t_frame f);
        fadf_pkg::t_result r;
        logic [47:0] age;
        logic        dup;
        r = '0;
        r.verdict = fadf_pkg::VERDICT_FWD;
        if (f.chk_known && !f.chk_pass) begin
            r.verdict = fadf_pkg::VERDICT_CRC;
        end else if (f.vehicle_side) begin
            last_vehicle_us = f.now_us;
            if (f.autopilot_heartbeat) begin
                if (!id_pinned) begin
                    id_pinned = 1'b1;
                    pinned_id = f.src_sys_id;
                end
                if (f.src_sys_id == pinned_id)
                    armed_now = f.hb_arm_flag;
            end
        end else begin
            dup = 1'b0;
            // ages wrap modulo 2^48, so a stamp later than now is recent only if now - stamp wraps below the window
            for (int i = 0; i < RING_DEPTH; i++) begin
                age = f.now_us - stamp_ring[i];
                if (hash_ring[i] == f.frame_hash && age < {16'd0, dedup_window})
                    dup = 1'b1;
            end
            if (dup) begin
                r.verdict = fadf_pkg::VERDICT_DUP;
            end else begin
                hash_ring[ring_pos]  = f.frame_hash;
                stamp_ring[ring_pos] = f.now_us;
                ring_pos = (ring_pos + 1 == RING_DEPTH) ? 0 : ring_pos + 1;
            end
        end
        r.toward_vehicle = (r.verdict == fadf_pkg::VERDICT_FWD) && !f.vehicle_side;
        r.priority_out   = (r.verdict == fadf_pkg::VERDICT_FWD) && f.prio_mark;
        r.armed          = armed_now;
        age              = f.now_us - last_vehicle_us;
        r.vehicle_recent = age < {16'd0, seen_window};
        return r;
    endfunction

    function void check_field(input string label, input logic [1:0] want,
                              input logic [1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        fadf_pkg::t_result want;
        fadf_pkg::t_result got;
        if (!i_rst_n) begin
            dedup_window = fadf_pkg::DEDUP_WINDOW_RST;
            seen_window  = fadf_pkg::SEEN_WINDOW_RST;
            for (int i = 0; i < RING_DEPTH; i++) begin
                hash_ring[i]  = 32'd0;
                stamp_ring[i] = 48'd0;
            end
            ring_pos        = 0;
            id_pinned       = 1'b0;
            pinned_id       = 8'd0;
            armed_now       = 1'b0;
            last_vehicle_us = 48'd0;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == fadf_pkg::REG_DEDUP_WINDOW)
                    dedup_window = i_pwdata;
                else
                    seen_window = i_pwdata;
            end
            if (i_out_tvalid && i_out_tready) begin
                got.verdict        = i_out_tuser;
                got.toward_vehicle = i_out_tdata[0];
                got.priority_out   = i_out_tdata[1];
                got.armed          = i_out_tdata[2];
                got.vehicle_recent = i_out_tdata[3];
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual %h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("verdict", want.verdict, got.verdict);
                    check_field("toward_vehicle", {1'b0, want.toward_vehicle},
                                {1'b0, got.toward_vehicle});
                    check_field("priority_out", {1'b0, want.priority_out},
                                {1'b0, got.priority_out});
                    check_field("armed", {1'b0, want.armed}, {1'b0, got.armed});
                    check_field("vehicle_recent", {1'b0, want.vehicle_recent},
                                {1'b0, got.vehicle_recent});
                end
            end
            if (i_in_tvalid && i_in_tready)
                expected_results.push_back(admit_frame(unpack_frame(i_in_tdata, i_in_tuser)));
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== verif/tb_frame_admission_dedup_filter.sv =====
// Testbench top for frame_admission_dedup_filter: clock, reset, APB setup, frame stimulus
// and receiver back-pressure; fadf_checker does prediction and comparison.
// Depends on fadf_pkg, the filter RTL and verif/fadf_checker.sv.
module tb_frame_admission_dedup_filter;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // chk_known, chk_pass, frame_hash[31:0], now_us[47:0], src_sys_id[7:0],
    // hb_arm_flag, prio_mark, zero fill
    logic [95:0] s_axis_tdata = '0;
    // vehicle_side, autopilot_heartbeat
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // toward_vehicle, priority_out, armed, vehicle_recent, zero fill
    logic [7:0]  m_axis_tdata;
    // verdict[1:0]
    logic [1:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          outstanding;
    int          frames_taken = 0;
    int          reg_writes = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    logic [47:0] clock_us = 48'd1_000_000;
    logic [31:0] hash_pool [12];

    frame_admission_dedup_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fadf_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tuser    (s_axis_tuser),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .i_out_tuser   (m_axis_tuser),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("frame_admission_dedup_filter verification failed");
        $finish;
    end

    // Count completed transactions so the drivers can wait on them at the falling edge.
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            frames_taken <= frames_taken + 1;
        if (psel && penable && pwrite && pready)
            reg_writes <= reg_writes + 1;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = 300;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic fadf_pkg::t_frame frame_of(input int fv, input int ck, input int cv,
                                                  input logic [31:0] hash,
                                                  input logic [47:0] now,
                                                  input int hb, input logic [7:0] sys,
                                                  input int arm, input int prio);
        fadf_pkg::t_frame f;
        f.vehicle_side        = 1'(fv);
        f.chk_known           = 1'(ck);
        f.chk_pass            = 1'(cv);
        f.frame_hash          = hash;
        f.now_us              = now;
        f.autopilot_heartbeat = 1'(hb);
        f.src_sys_id          = sys;
        f.hb_arm_flag         = 1'(arm);
        f.prio_mark           = 1'(prio);
        return f;
    endfunction

    // Starts and ends at a falling edge; valid stays high after the transaction.
    task automatic send_frame(input fadf_pkg::t_frame f);
        int taken;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {f.autopilot_heartbeat, f.vehicle_side};
        s_axis_tdata  <= {4'd0, f.prio_mark, f.hb_arm_flag, f.src_sys_id, f.now_us,
                          f.frame_hash, f.chk_pass, f.chk_known};
        taken = frames_taken;
        do @(negedge i_clk); while (frames_taken == taken);
    endtask

    // Write both windows back to back; psel stays high between the two transactions.
    task automatic set_windows(input logic [31:0] dedup_us, input logic [31:0] seen_us);
        int done;
        for (int k = 0; k < 2; k++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {(k == 0) ? fadf_pkg::REG_DEDUP_WINDOW : fadf_pkg::REG_SEEN_WINDOW,
                        2'b00};
            pwdata  <= (k == 0) ? dedup_us : seen_us;
            @(negedge i_clk);
            penable <= 1'b1;
            done = reg_writes;
            do @(negedge i_clk); while (reg_writes == done);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_frame(output fadf_pkg::t_frame f);
        int unsigned pick;
        logic [31:0] fresh;
        // advance mostly in small steps, sometimes far, back, or anywhere
        pick = $urandom_range(99);
        if (pick < 75)
            clock_us += $urandom_range(20000);
        else if (pick < 88)
            clock_us += $urandom_range(4_000_000);
        else if (pick < 95)
            clock_us -= $urandom_range(60000);
        else
            clock_us = 48'({$urandom, $urandom});
        f.now_us = clock_us;

        pick = $urandom_range(99);
        if (pick < 55) begin
            f.frame_hash = hash_pool[$urandom_range(11)];
        end else if (pick < 60) begin
            f.frame_hash = 32'd0;
        end else begin
            fresh = $urandom;
            hash_pool[$urandom_range(11)] = fresh;
            f.frame_hash = fresh;
        end

        pick = $urandom_range(99);
        f.chk_known = !(pick >= 12 && pick < 24);
        f.chk_pass  = (pick < 12) ? 1'b0 : (pick < 24) ? 1'($urandom_range(1)) : 1'b1;

        f.vehicle_side        = ($urandom_range(99) < 35);
        f.autopilot_heartbeat = ($urandom_range(99) < 45);
        f.src_sys_id          = ($urandom_range(99) < 65) ? 8'd1 : 8'($urandom_range(255));
        f.hb_arm_flag         = 1'($urandom_range(1));
        f.prio_mark           = 1'($urandom_range(1));
    endtask

    initial begin
        fadf_pkg::t_frame f;
        for (int k = 0; k < 12; k++)
            hash_pool[k] = $urandom;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at reset windows: cleared ring, wrap of ages, pinning, checksum drops.
        send_frame(frame_of(0, 1, 1, 32'h0000_0000, 48'd0, 0, 8'd0, 0, 1));
        send_frame(frame_of(0, 1, 1, 32'h0000_0000, 48'd60000, 0, 8'd0, 0, 0));
        send_frame(frame_of(0, 1, 1, 32'h1234_5678, 48'd61000, 0, 8'd0, 0, 1));
        send_frame(frame_of(0, 1, 1, 32'h1234_5678, 48'd62000, 0, 8'd0, 0, 1));
        send_frame(frame_of(0, 1, 1, 32'h1234_5678, 48'd60500, 0, 8'd0, 0, 0));
        send_frame(frame_of(0, 1, 0, 32'h1234_5678, 48'd70000, 0, 8'd0, 0, 1));
        send_frame(frame_of(0, 0, 0, 32'hFFFF_FFFF, 48'd70001, 0, 8'd0, 0, 1));
        send_frame(frame_of(1, 1, 1, 32'hFFFF_FFFF, 48'd100000, 0, 8'd0, 0, 1));
        send_frame(frame_of(1, 1, 1, 32'h0000_0000, 48'd100010, 1, 8'd1, 1, 0));
        send_frame(frame_of(1, 1, 1, 32'h0000_0001, 48'd100020, 1, 8'd2, 0, 0));
        send_frame(frame_of(0, 1, 1, 32'hA5A5_5A5A, 48'd100030, 1, 8'd1, 0, 0));
        send_frame(frame_of(1, 1, 1, 32'h0000_0002, 48'd100040, 1, 8'd1, 0, 1));
        send_frame(frame_of(1, 1, 1, 32'h0000_0003, 48'd100050, 1, 8'd1, 1, 0));
        send_frame(frame_of(1, 1, 0, 32'h0000_0004, 48'd100060, 1, 8'd1, 0, 1));
        send_frame(frame_of(1, 0, 1, 32'h0000_0005, 48'd100070, 1, 8'hFF, 0, 1));
        send_frame(frame_of(1, 1, 1, 32'h0000_0006, 48'd100080, 1, 8'h00, 0, 0));
        send_frame(frame_of(0, 1, 1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 8'hFF, 1, 1));
        send_frame(frame_of(1, 1, 1, 32'h5555_AAAA, 48'hFFFF_FFFF_FFFF, 0, 8'hFF, 1, 1));
        send_frame(frame_of(0, 1, 1, 32'h0F0F_0F0F, 48'd5, 0, 8'd0, 0, 0));
        send_frame(frame_of(0, 1, 1, 32'hFFFF_FFFF, 48'd10, 0, 8'd0, 0, 1));
        send_frame(frame_of(0, 1, 1, 32'hF0F0_F0F0, 48'd3_200_000, 0, 8'd0, 0, 0));
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            unique case (ph)
                0: begin
                    set_windows(32'd0, 32'hFFFF_FFFF);
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                1: begin
                    set_windows(32'hFFFF_FFFF, 32'd0);
                    tx_idle_pct = 63;
                    rx_idle_pct = 0;
                end
                2: begin
                    set_windows($urandom_range(200_000, 1000), $urandom_range(10_000_000, 1000));
                    tx_idle_pct = 0;
                    rx_idle_pct = 63;
                end
                default: begin
                    set_windows(fadf_pkg::DEDUP_WINDOW_RST, fadf_pkg::SEEN_WINDOW_RST);
                    tx_idle_pct = 28;
                    rx_idle_pct = 28;
                end
            endcase
            for (int n = 0; n < 225; n++) begin
                // long receiver hold-off while frames keep coming
                if (ph == 0 && n == 40)
                    hold_reqs++;
                random_frame(f);
                send_frame(f);
            end
            s_axis_tvalid <= 1'b0;
            while (outstanding != 0) @(negedge i_clk);
        end

        repeat (fadf_pkg::RING_DEPTH_DEF + 8) @(negedge i_clk);
        if (fail_count == 0)
            $display("frame_admission_dedup_filter verification clean");
        else
            $display("frame_admission_dedup_filter verification failed");
        $finish;
    end

endmodule
